// ----- rtl/core/lifetime_aware_region_placer_defines.svh -----
// assertion helpers for the region placer
`ifndef LIFETIME_AWARE_REGION_PLACER_DEFINES_SVH
`define LIFETIME_AWARE_REGION_PLACER_DEFINES_SVH

// same-cycle implication
`define LAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lar_pkg.sv -----
`default_nettype none
package lar_pkg;
    localparam int CTX_W   = 4;
    localparam int SIZE_W  = 32;
    localparam int ALIGN_W = 16;
    localparam int OUT_W   = 32;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic OP_PLACE = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD  = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL = 2'd2;
    localparam logic [ST_W-1:0] ST_OVF  = 2'd3;
endpackage
`default_nettype wire

// ----- rtl/core/lar_seg_mem.sv -----
`default_nettype none
module lar_seg_mem #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 72
) (
    input  wire                       aclk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [DATA_W-1:0]         wdata,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [DATA_W-1:0]         rdata
);
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/lar_rem.sv -----
`default_nettype none
module lar_rem #(
    parameter int DVD_W = 32
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [DVD_W-1:0]             dividend,
    input  wire  [lar_pkg::ALIGN_W-1:0]  divisor,
    output logic                         done,
    output logic [lar_pkg::ALIGN_W-1:0]  rem
);
    import lar_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [ALIGN_W:0]   rem_reg;
    logic [ALIGN_W:0]   trial;

    // restoring remainder, one dividend bit per cycle
    assign trial = {rem_reg[ALIGN_W-1:0], dvd_reg[DVD_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << 1;
            if (trial >= {1'b0, divisor}) begin
                rem_reg <= trial - {1'b0, divisor};
            end else begin
                rem_reg <= trial;
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg[ALIGN_W-1:0];
endmodule
`default_nettype wire

// ----- rtl/core/lifetime_aware_region_placer.sv -----
// channel  | dir | beat contents (low bits first)
// s_       | in  | tuser: op; tdata: first_context, last_context, region_size, alignment
// m_       | out | tdata: placed_offset, total_size, status
// cfg_     | in  | contexts_in_use, written on cfg_we
// one beat at a time; clear, bad range and list full answer 2 cycles after accept
// a place, or an overflow found after the scan, takes 2 cycles per stored segment,
// plus ADDR_BITS+1 cycles per remainder run, plus 2 cycles per segment moved on insert
// all stored segments sit in one offset-sorted list memory with one read port
// reset clears counts and total at once, no clearing pass
// a result waiting on m_tready holds the block in its response state
`default_nettype none
`include "lifetime_aware_region_placer_defines.svh"
module lifetime_aware_region_placer #(
    parameter int NUM_CONTEXTS     = 16,
    parameter int SEGS_PER_CONTEXT = 64,
    parameter int ADDR_BITS        = 32
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_we,
    input  wire  [lar_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [55:0]                 s_tdata,   // first_context, last_context, region_size, alignment
    input  wire                         s_tuser,   // op
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [71:0]                 m_tdata    // placed_offset, total_size, status
);
    import lar_pkg::*;

    localparam int TOTAL  = NUM_CONTEXTS * SEGS_PER_CONTEXT;
    localparam int IDX_W  = $clog2(TOTAL);
    localparam int CNT_W  = $clog2(TOTAL + 1);
    localparam int SCNT_W = $clog2(SEGS_PER_CONTEXT + 1);
    localparam int CW     = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 2;
    localparam int ENT_W  = 2 * ADDR_BITS + 2 * CTX_W;
    localparam logic [CW-1:0] ADDR_MAX = (CW'(1) << ADDR_BITS) - CW'(1);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN_RD = 4'd1;
    localparam logic [3:0] S_SCAN_EV = 4'd2;
    localparam logic [3:0] S_DIV     = 4'd3;
    localparam logic [3:0] S_FINAL   = 4'd4;
    localparam logic [3:0] S_COMMIT  = 4'd5;
    localparam logic [3:0] S_INS_RD  = 4'd6;
    localparam logic [3:0] S_INS_EV  = 4'd7;
    localparam logic [3:0] S_RESP    = 4'd8;

    localparam logic [1:0] D_FIRST = 2'd0;
    localparam logic [1:0] D_GAP   = 2'd1;
    localparam logic [1:0] D_LAST  = 2'd2;

    logic [3:0]          state_reg, state_next;
    logic [CFG_W-1:0]    cfg_reg;
    logic [SCNT_W-1:0]   cnt_reg  [NUM_CONTEXTS];
    logic [SCNT_W-1:0]   cnt_next [NUM_CONTEXTS];
    logic [CNT_W-1:0]    gcnt_reg, gcnt_next;
    logic [ADDR_BITS-1:0] total_reg, total_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                have_reg, have_next;
    logic [ADDR_BITS-1:0] cend_reg, cend_next;
    logic [ADDR_BITS-1:0] pend_reg, pend_next;
    logic [ADDR_BITS-1:0] nxt_reg, nxt_next;
    logic [1:0]          dmode_reg, dmode_next;
    logic [CW-1:0]       place_reg, place_next;
    logic [OUT_W-1:0]    res_off_reg, res_off_next;
    logic [ST_W-1:0]     res_st_reg, res_st_next;
    logic                m_valid_reg, m_valid_next;
    logic [71:0]         m_data_reg, m_data_next;

    logic [CTX_W-1:0]    req_f_reg, req_l_reg;
    logic [SIZE_W-1:0]   req_size_reg;
    logic [ALIGN_W-1:0]  req_align_reg;
    logic                req_load;

    logic [CTX_W-1:0]    in_first, in_last;
    logic [SIZE_W-1:0]   in_size;
    logic [ALIGN_W-1:0]  in_align;
    logic                bad_range, list_full;
    int                  eff;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr, mem_raddr;
    logic [ENT_W-1:0]    mem_wdata, mem_rdata, new_ent;
    logic [ADDR_BITS-1:0] rd_off, rd_end;
    logic [CTX_W-1:0]    rd_first, rd_last;
    logic                rd_hit;

    logic                div_start, div_done;
    logic [ADDR_BITS-1:0] div_dvd;
    logic [ALIGN_W-1:0]  div_rem;
    logic [CW-1:0]       remx, ae, end_sum, size_x;
    logic                fin;

    assign in_first = s_tdata[3:0];
    assign in_last  = s_tdata[7:4];
    assign in_size  = s_tdata[39:8];
    assign in_align = s_tdata[55:40];

    assign eff       = (int'(cfg_reg) > NUM_CONTEXTS) ? NUM_CONTEXTS : int'(cfg_reg);
    assign bad_range = (in_first > in_last) || (int'(in_last) >= eff);

    always_comb begin
        list_full = 1'b0;
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
            if (c >= int'(in_first) && c <= int'(in_last)
                && cnt_reg[c] >= SCNT_W'(SEGS_PER_CONTEXT)) begin
                list_full = 1'b1;
            end
        end
    end

    assign rd_off   = mem_rdata[ADDR_BITS-1:0];
    assign rd_end   = mem_rdata[2*ADDR_BITS-1:ADDR_BITS];
    assign rd_last  = mem_rdata[2*ADDR_BITS+CTX_W-1:2*ADDR_BITS];
    assign rd_first = mem_rdata[ENT_W-1:2*ADDR_BITS+CTX_W];
    assign rd_hit   = (rd_first <= req_l_reg) && (rd_last >= req_f_reg);

    assign size_x  = CW'(req_size_reg);
    assign remx    = CW'(div_rem);
    assign ae      = (div_rem == '0) ? CW'(cend_reg)
                                     : CW'(cend_reg) - remx + CW'(req_align_reg);
    assign end_sum = place_reg + size_x;
    assign new_ent = {req_f_reg, req_l_reg, end_sum[ADDR_BITS-1:0], place_reg[ADDR_BITS-1:0]};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        gcnt_next    = gcnt_reg;
        total_next   = total_reg;
        idx_next     = idx_reg;
        have_next    = have_reg;
        cend_next    = cend_reg;
        pend_next    = pend_reg;
        nxt_next     = nxt_reg;
        dmode_next   = dmode_reg;
        place_next   = place_reg;
        res_off_next = res_off_reg;
        res_st_next  = res_st_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        req_load     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = idx_reg[IDX_W-1:0];
        mem_wdata    = new_ent;
        mem_raddr    = idx_reg[IDX_W-1:0];
        div_start    = 1'b0;
        div_dvd      = cend_reg;
        fin          = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    res_off_next = '0;
                    state_next   = S_RESP;
                    if (s_tuser == OP_CLEAR) begin
                        for (int c = 0; c < NUM_CONTEXTS; c++) begin
                            cnt_next[c] = '0;
                        end
                        gcnt_next   = '0;
                        total_next  = '0;
                        res_st_next = ST_OK;
                    end else if (bad_range) begin
                        res_st_next = ST_BAD;
                    end else if (list_full) begin
                        res_st_next = ST_FULL;
                    end else begin
                        req_load   = 1'b1;
                        idx_next   = '0;
                        have_next  = 1'b0;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (idx_reg == gcnt_reg) begin
                    state_next = S_FINAL;
                end else begin
                    state_next = S_SCAN_EV;
                end
            end
            S_SCAN_EV: begin
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_SCAN_RD;
                if (rd_hit) begin
                    if (!have_reg) begin
                        have_next = 1'b1;
                        cend_next = rd_end;
                        nxt_next  = rd_off;
                        if (CW'(rd_off) >= size_x) begin
                            div_start  = 1'b1;
                            div_dvd    = rd_off;
                            dmode_next = D_FIRST;
                            state_next = S_DIV;
                        end
                    end else if (cend_reg >= rd_off) begin
                        if (rd_end > cend_reg) begin
                            cend_next = rd_end;
                        end
                    end else if (CW'(rd_off) - CW'(cend_reg) >= size_x) begin
                        div_start  = 1'b1;
                        nxt_next   = rd_off;
                        pend_next  = rd_end;
                        dmode_next = D_GAP;
                        state_next = S_DIV;
                    end else begin
                        cend_next = rd_end;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_SCAN_RD;
                    case (dmode_reg)
                        D_FIRST: begin
                            if (CW'(nxt_reg) - remx >= size_x) begin
                                place_next = '0;
                                state_next = S_COMMIT;
                            end
                        end
                        D_GAP: begin
                            if (CW'(nxt_reg) >= ae && CW'(nxt_reg) - ae >= size_x) begin
                                place_next = ae;
                                state_next = S_COMMIT;
                            end else begin
                                cend_next = pend_reg;
                            end
                        end
                        default: begin
                            place_next = ae;
                            state_next = S_COMMIT;
                        end
                    endcase
                end
            end
            S_FINAL: begin
                if (!have_reg) begin
                    place_next = '0;
                    state_next = S_COMMIT;
                end else begin
                    div_start  = 1'b1;
                    dmode_next = D_LAST;
                    state_next = S_DIV;
                end
            end
            S_COMMIT: begin
                if (end_sum > ADDR_MAX) begin
                    res_off_next = '0;
                    res_st_next  = ST_OVF;
                    state_next   = S_RESP;
                end else begin
                    idx_next   = gcnt_reg;
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    mem_we = 1'b1;
                    fin    = 1'b1;
                end else begin
                    mem_raddr  = IDX_W'(idx_reg - CNT_W'(1));
                    state_next = S_INS_EV;
                end
            end
            S_INS_EV: begin
                mem_we = 1'b1;
                if (rd_off > place_reg[ADDR_BITS-1:0]) begin
                    mem_wdata  = mem_rdata;
                    idx_next   = idx_reg - CNT_W'(1);
                    state_next = S_INS_RD;
                end else begin
                    fin = 1'b1;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'b0, res_st_reg, OUT_W'(total_reg), res_off_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (fin) begin
            gcnt_next = gcnt_reg + CNT_W'(1);
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                if (c >= int'(req_f_reg) && c <= int'(req_l_reg)) begin
                    cnt_next[c] = cnt_reg[c] + SCNT_W'(1);
                end
            end
            if (end_sum > CW'(total_reg)) begin
                total_next = end_sum[ADDR_BITS-1:0];
            end
            res_off_next = OUT_W'(place_reg);
            res_st_next  = ST_OK;
            state_next   = S_RESP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cfg_reg     <= CFG_RESET;
            gcnt_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
                cnt_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            gcnt_reg    <= gcnt_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            if (cfg_we) begin
                cfg_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        have_reg    <= have_next;
        cend_reg    <= cend_next;
        pend_reg    <= pend_next;
        nxt_reg     <= nxt_next;
        dmode_reg   <= dmode_next;
        place_reg   <= place_next;
        res_off_reg <= res_off_next;
        res_st_reg  <= res_st_next;
        m_data_reg  <= m_data_next;
        if (req_load) begin
            req_f_reg     <= in_first;
            req_l_reg     <= in_last;
            req_size_reg  <= in_size;
            req_align_reg <= (in_align == '0) ? ALIGN_W'(1) : in_align;
        end
    end

    lar_seg_mem #(
        .DEPTH  (TOTAL),
        .DATA_W (ENT_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lar_rem #(
        .DVD_W (ADDR_BITS)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (req_align_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    `LAR_ASSERT_NOW(a_rem_done_in_div, div_done, state_reg == S_DIV, "remainder ready outside wait")
    `LAR_ASSERT_NEXT(a_clear_empties, s_tvalid && s_tready && s_tuser == OP_CLEAR, gcnt_reg == '0 && total_reg == '0, "clear left state")
    `LAR_ASSERT_NOW(a_write_in_insert, mem_we, state_reg == S_INS_RD || state_reg == S_INS_EV, "list written outside insert")
    `LAR_ASSERT_NOW(a_list_bound, 1'b1, int'(gcnt_reg) <= TOTAL, "segment list overrun")
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
module testbench;
    import lar_pkg::*;

    localparam int NCTX = 16;
    localparam int SEGS = 64;

    typedef struct packed {
        logic       op;
        logic [3:0] first_ctx;
        logic [3:0] last_ctx;
        logic [31:0] size;
        logic [15:0] align;
    } place_req_t;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] total;
        logic [1:0]  status;
    } place_rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [55:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [71:0] m_tdata;

    place_req_t pending_reqs[$];
    place_rsp_t expected_rsps[$];
    int         errors = 0;
    int         accepted = 0;
    bit         calm = 0;

    // shadow of the allocator state
    logic [63:0] seg_off[NCTX][SEGS];
    logic [63:0] seg_len[NCTX][SEGS];
    int          seg_cnt[NCTX];
    logic [63:0] run_total;
    logic [4:0]  ctx_limit;

    lifetime_aware_region_placer u_dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] align_up(logic [63:0] v, logic [63:0] a);
        return ((v + a - 1) / a) * a;
    endfunction

    function automatic void add_req(place_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endfunction

    function automatic place_rsp_t allocate_region(place_req_t r);
        place_rsp_t  rsp;
        logic [63:0] offs[$];
        logic [63:0] ends[$];
        logic [63:0] moff[$];
        logic [63:0] mend[$];
        logic [63:0] a, sz, place, ae, nxt, max_end;
        int          eff, j;
        bit          found;
        rsp = '0;
        if (r.op == OP_CLEAR) begin
            for (int c = 0; c < NCTX; c++) seg_cnt[c] = 0;
            run_total = 0;
            rsp.status = ST_OK;
            return rsp;
        end
        eff = (ctx_limit > NCTX) ? NCTX : ctx_limit;
        a = (r.align == 0) ? 64'd1 : 64'(r.align);
        sz = 64'(r.size);
        rsp.total = run_total[31:0];
        if (r.first_ctx > r.last_ctx || int'(r.last_ctx) >= eff) begin
            rsp.status = ST_BAD;
            return rsp;
        end
        for (int c = r.first_ctx; c <= r.last_ctx; c++)
            if (seg_cnt[c] >= SEGS) begin
                rsp.status = ST_FULL;
                return rsp;
            end
        for (int c = r.first_ctx; c <= r.last_ctx; c++)
            for (int i = 0; i < seg_cnt[c]; i++) begin
                j = offs.size();
                while (j > 0 && offs[j-1] > seg_off[c][i]) j--;
                offs.insert(j, seg_off[c][i]);
                ends.insert(j, seg_off[c][i] + seg_len[c][i]);
            end
        foreach (offs[i]) begin
            if (mend.size() > 0 && mend[$] >= offs[i]) begin
                if (ends[i] > mend[$]) mend[mend.size()-1] = ends[i];
            end else begin
                moff.insert(moff.size(), offs[i]);
                mend.insert(mend.size(), ends[i]);
            end
        end
        place = 0;
        found = 0;
        if (moff.size() > 0 && (moff[0] / a) * a >= sz) begin
            found = 1;
        end else if (moff.size() > 0) begin
            max_end = mend[$];
            for (int i = 0; i < moff.size() && !found; i++) begin
                ae = align_up(mend[i], a);
                nxt = (i + 1 < moff.size()) ? moff[i+1] : max_end;
                if (nxt >= ae && nxt - ae >= sz) begin
                    place = ae;
                    found = 1;
                end
            end
            if (!found) place = align_up(max_end, a);
        end
        if (place + sz > 64'hFFFF_FFFF) begin
            rsp.status = ST_OVF;
            return rsp;
        end
        for (int c = r.first_ctx; c <= r.last_ctx; c++) begin
            seg_off[c][seg_cnt[c]] = place;
            seg_len[c][seg_cnt[c]] = sz;
            seg_cnt[c]++;
        end
        if (place + sz > run_total) run_total = place + sz;
        rsp.offset = place[31:0];
        rsp.total = run_total[31:0];
        rsp.status = ST_OK;
        return rsp;
    endfunction

    // driver
    always @(posedge aclk) begin
        place_req_t nxt_req;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                allocate_region_push({s_tuser, s_tdata});
                accepted <= accepted + 1;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
                    nxt_req = pending_reqs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= nxt_req.op;
                    s_tdata <= {nxt_req.align, nxt_req.size, nxt_req.last_ctx,
                                nxt_req.first_ctx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic allocate_region_push(logic [56:0] beat);
        place_req_t r;
        r.op = beat[56];
        r.first_ctx = beat[3:0];
        r.last_ctx = beat[7:4];
        r.size = beat[39:8];
        r.align = beat[55:40];
        expected_rsps.insert(expected_rsps.size(), allocate_region(r));
    endtask

    // monitor
    always @(posedge aclk) begin
        place_rsp_t got, exp_rsp;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.offset = m_tdata[31:0];
                got.total = m_tdata[63:32];
                got.status = m_tdata[65:64];
                if (expected_rsps.size() == 0) begin
                    $error("unexpected result beat");
                    errors++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (got.offset !== exp_rsp.offset) begin
                        $error("placed_offset exp %0h got %0h", exp_rsp.offset, got.offset);
                        errors++;
                    end
                    if (got.total !== exp_rsp.total) begin
                        $error("total_size exp %0h got %0h", exp_rsp.total, got.total);
                        errors++;
                    end
                    if (got.status !== exp_rsp.status) begin
                        $error("status exp %0d got %0d", exp_rsp.status, got.status);
                        errors++;
                    end
                end
            end
            m_tready <= calm || ($urandom_range(99) >= 38);
        end
    end

    function automatic place_req_t mk(logic op, int f, int l, logic [31:0] sz,
                                      logic [15:0] al);
        place_req_t r;
        r.op = op;
        r.first_ctx = f[3:0];
        r.last_ctx = l[3:0];
        r.size = sz;
        r.align = al;
        return r;
    endfunction

    function automatic place_req_t rand_req();
        int f, l, pick;
        logic [15:0] al;
        logic [31:0] sz;
        pick = $urandom_range(99);
        f = $urandom_range(15);
        l = (pick < 85) ? $urandom_range(15, f) : $urandom_range(15);
        case ($urandom_range(3))
            0: al = 16'd1 << $urandom_range(12);
            1: al = 16'($urandom);
            2: al = 16'd0;
            default: al = 16'd64;
        endcase
        case ($urandom_range(9))
            0: sz = $urandom;
            1: sz = 32'hFFFF_FFFF - $urandom_range(255);
            2: sz = 0;
            default: sz = $urandom_range(4096);
        endcase
        if (pick >= 97) return mk(OP_CLEAR, $urandom_range(15), $urandom_range(15),
                                  $urandom, 16'($urandom));
        return mk(OP_PLACE, f, l, sz, al);
    endfunction

    task automatic drain_and_cfg(logic [4:0] v);
        wait (pending_reqs.size() == 0 && !s_tvalid && expected_rsps.size() == 0);
        repeat (20) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        ctx_limit = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        ctx_limit = CFG_RESET;
        run_total = 0;
        for (int c = 0; c < NCTX; c++) seg_cnt[c] = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: extremes, errors, fits and gaps
        add_req(mk(OP_PLACE, 0, 0, 32'd100, 16'd0));
        add_req(mk(OP_PLACE, 0, 15, 32'd0, 16'hFFFF));
        add_req(mk(OP_PLACE, 3, 2, 32'd10, 16'd1));
        add_req(mk(OP_PLACE, 1, 1, 32'd50, 16'd16));
        add_req(mk(OP_PLACE, 0, 1, 32'd20, 16'd8));
        add_req(mk(OP_PLACE, 0, 0, 32'hFFFF_FFFF, 16'd1));
        add_req(mk(OP_PLACE, 15, 15, 32'hFFFF_FFFF, 16'd1));
        add_req(mk(OP_CLEAR, 15, 0, 32'hFFFF_FFFF, 16'hFFFF));
        add_req(mk(OP_PLACE, 2, 2, 32'd1000, 16'd1));
        add_req(mk(OP_PLACE, 3, 3, 32'd10, 16'd1));
        add_req(mk(OP_PLACE, 2, 3, 32'd5, 16'd4));
        add_req(mk(OP_PLACE, 4, 4, 32'h8000_0000, 16'h8000));
        add_req(mk(OP_PLACE, 4, 4, 32'h7FFF_FFFF, 16'd1));
        for (int i = 0; i < 65; i++) add_req(mk(OP_PLACE, 9, 9, 32'd1, 16'd1));
        add_req(mk(OP_PLACE, 8, 10, 32'd1, 16'd1));
        add_req(mk(OP_CLEAR, 0, 0, 32'd0, 16'd0));
        drain_and_cfg(5'd1);
        add_req(mk(OP_PLACE, 0, 0, 32'd7, 16'd2));
        add_req(mk(OP_PLACE, 0, 1, 32'd7, 16'd2));
        drain_and_cfg(5'd0);
        add_req(mk(OP_PLACE, 0, 0, 32'd7, 16'd2));
        drain_and_cfg(5'd31);
        add_req(mk(OP_PLACE, 15, 15, 32'd7, 16'd2));
        drain_and_cfg(5'd16);
        // random phases, long calm stretch in the middle
        for (int p = 0; p < 4; p++) begin
            calm = (p == 2);
            for (int i = 0; i < 14; i++) add_req(rand_req());
            drain_and_cfg(p == 0 ? 5'd8 : (p == 1 ? 5'd16 : (p == 2 ? 5'd3 : 5'd16)));
        end
        calm = 0;
        repeat (20) @(posedge aclk);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
`default_nettype wire
